/* design/usbsrh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package usbsrh_pkg;

  localparam int unsigned EndpointCount = 8;
  localparam int unsigned StringCount   = 4;
  localparam int unsigned EpIdxW        = $clog2(EndpointCount);
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QPtrW         = $clog2(QueueDepth);
  localparam int unsigned QCountW       = $clog2(QueueDepth + 1);

  localparam logic [6:0] DevDescBytes   = 7'd18;
  localparam logic [6:0] StrDescBytes   = 7'd42;
  localparam logic [6:0] CfgDescDefault = 7'd90;
  localparam logic [3:0] LineLenDefault = 4'd7;

  // Request ids: bRequest in the high byte, bmRequestType in the low byte
  localparam logic [15:0] ReqGetDescriptor = 16'h0680;
  localparam logic [15:0] ReqSetAddress    = 16'h0500;
  localparam logic [15:0] ReqSetConfig     = 16'h0900;
  localparam logic [15:0] ReqGetConfig     = 16'h0880;
  localparam logic [15:0] ReqGetStatusDev  = 16'h0080;
  localparam logic [15:0] ReqGetStatusIf   = 16'h0081;
  localparam logic [15:0] ReqGetStatusEp   = 16'h0082;
  localparam logic [15:0] ReqSetFeatDev    = 16'h0300;
  localparam logic [15:0] ReqClrFeatDev    = 16'h0100;
  localparam logic [15:0] ReqSetFeatIf     = 16'h0301;
  localparam logic [15:0] ReqClrFeatIf     = 16'h0101;
  localparam logic [15:0] ReqSetLineCoding = 16'h2021;
  localparam logic [15:0] ReqSetFeatEp     = 16'h0302;
  localparam logic [15:0] ReqClrFeatEp     = 16'h0102;
  localparam logic [15:0] ReqGetLineCoding = 16'h21A1;
  localparam logic [15:0] ReqSetLineState  = 16'h2221;
  localparam logic [15:0] ReqMscReset      = 16'hFF21;
  localparam logic [15:0] ReqGetMaxLun     = 16'hFEA1;

  localparam logic [15:0] DescDevice = 16'h0100;
  localparam logic [15:0] DescConfig = 16'h0200;
  localparam logic [7:0]  DescString = 8'h03;

  typedef enum logic [1:0] {
    CFG_DESC_LEN = 2'd0,
    CFG_MAX_LUN  = 2'd1,
    CFG_LINE_LEN = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_ZLP       = 3'd2,
    KIND_STALL     = 3'd3,
    KIND_MSC_RESET = 3'd4
  } reply_kind_e;

  typedef enum logic [2:0] {
    SRC_NONE   = 3'd0,
    SRC_DEV    = 3'd1,
    SRC_CFG    = 3'd2,
    SRC_STR    = 3'd3,
    SRC_CFGVAL = 3'd4,
    SRC_STATUS = 3'd5,
    SRC_LINE   = 3'd6,
    SRC_LUN    = 3'd7
  } data_src_e;

  typedef enum logic [3:0] {
    OP_BUS_RESET,
    OP_GET_DEV,
    OP_GET_CFG,
    OP_GET_STR,
    OP_STALL,
    OP_SET_ADDR,
    OP_SET_CFG,
    OP_GET_CFGVAL,
    OP_STATUS_ZERO,
    OP_EP_STATUS,
    OP_ZLP,
    OP_SET_HALT,
    OP_CLR_HALT,
    OP_GET_LINE,
    OP_SET_LINE,
    OP_MSC_RESET
  } op_e;

  // Get max LUN is the one request left over; it shares OP_STATUS_ZERO and is marked by get_lun
  typedef struct packed {
    op_e                 op;
    logic                get_lun;
    logic [15:0]         value;
    logic [15:0]         length;
    logic [EpIdxW-1:0]   ep;
    logic                dir_in;
  } req_item_t;

endpackage

`default_nettype wire

/* design/usb_standard_request_handler.sv */
// Path: an accepted request passes the classify register, the two-entry queue and the result
// register in that order; empty drops once it sits in the result register, ready to pop.
// Throughput: one request per cycle sustained while results are popped; full only rises
// when the result register waits unpopped, the queue holds two requests and the classify register a third.
// Reset: device address, configuration, line state and all halt flags clear; the
// registers return to 90, 0 and 7; queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none

module usb_standard_request_handler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action_i,
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_code_i,
  input  wire logic [15:0] value_word_i,
  input  wire logic [15:0] index_word_i,
  input  wire logic [15:0] length_word_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       reply_kind_o,
  output logic [2:0]       data_source_o,
  output logic [1:0]       string_number_o,
  output logic [7:0]       send_length_o,
  output logic [15:0]      reply_word_o,
  output logic [6:0]       device_address_now_o,
  output logic             is_configured_o
);

  logic                  front_valid;
  logic                  queue_ready;
  usbsrh_pkg::req_item_t front_item;
  logic                  queue_valid;
  logic                  queue_take;
  usbsrh_pkg::req_item_t queue_item;

  usbsrh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .request_type_i (request_type_i),
    .request_code_i (request_code_i),
    .value_word_i   (value_word_i),
    .index_word_i   (index_word_i),
    .length_word_i  (length_word_i),
    .item_valid_o   (front_valid),
    .item_ready_i   (queue_ready),
    .item_o         (front_item)
  );

  usbsrh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (queue_ready),
    .wr_item_i  (front_item),
    .rd_valid_o (queue_valid),
    .rd_take_i  (queue_take),
    .rd_item_o  (queue_item)
  );

  usbsrh_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .item_valid_i         (queue_valid),
    .item_take_o          (queue_take),
    .item_i               (queue_item),
    .empty                (empty),
    .pop                  (pop),
    .reply_kind_o         (reply_kind_o),
    .data_source_o        (data_source_o),
    .string_number_o      (string_number_o),
    .send_length_o        (send_length_o),
    .reply_word_o         (reply_word_o),
    .device_address_now_o (device_address_now_o),
    .is_configured_o      (is_configured_o)
  );

endmodule

`default_nettype wire

/* design/usbsrh_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module usbsrh_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  action_i,
  input  wire logic [7:0]            request_type_i,
  input  wire logic [7:0]            request_code_i,
  input  wire logic [15:0]           value_word_i,
  input  wire logic [15:0]           index_word_i,
  input  wire logic [15:0]           length_word_i,
  output logic                       item_valid_o,
  input  wire logic                  item_ready_i,
  output usbsrh_pkg::req_item_t      item_o
);

  logic                  valid_q, valid_d;
  usbsrh_pkg::req_item_t item_q;
  usbsrh_pkg::req_item_t item_c;
  logic                  accept;
  logic [15:0]           req_id;
  logic                  ep_in_range;
  logic                  str_in_range;

  assign full   = valid_q && !item_ready_i;
  assign accept = push && !full;

  assign req_id       = {request_code_i, request_type_i};
  assign ep_in_range  = 32'(index_word_i[3:0]) < usbsrh_pkg::EndpointCount;
  assign str_in_range = 32'(value_word_i[7:0]) < usbsrh_pkg::StringCount;

  always_comb begin
    item_c.op      = usbsrh_pkg::OP_STALL;
    item_c.get_lun = 1'b0;
    item_c.value   = value_word_i;
    item_c.length  = length_word_i;
    item_c.ep      = index_word_i[usbsrh_pkg::EpIdxW-1:0];
    item_c.dir_in  = index_word_i[7];
    if (action_i) begin
      item_c.op = usbsrh_pkg::OP_BUS_RESET;
    end else begin
      unique case (req_id)
        usbsrh_pkg::ReqGetDescriptor: begin
          if (value_word_i == usbsrh_pkg::DescDevice) begin
            item_c.op = usbsrh_pkg::OP_GET_DEV;
          end else if (value_word_i == usbsrh_pkg::DescConfig) begin
            item_c.op = usbsrh_pkg::OP_GET_CFG;
          end else if (value_word_i[15:8] == usbsrh_pkg::DescString && str_in_range) begin
            item_c.op = usbsrh_pkg::OP_GET_STR;
          end else begin
            item_c.op = usbsrh_pkg::OP_STALL;
          end
        end
        usbsrh_pkg::ReqSetAddress:    item_c.op = usbsrh_pkg::OP_SET_ADDR;
        usbsrh_pkg::ReqSetConfig:     item_c.op = usbsrh_pkg::OP_SET_CFG;
        usbsrh_pkg::ReqGetConfig:     item_c.op = usbsrh_pkg::OP_GET_CFGVAL;
        usbsrh_pkg::ReqGetStatusDev,
        usbsrh_pkg::ReqGetStatusIf:   item_c.op = usbsrh_pkg::OP_STATUS_ZERO;
        usbsrh_pkg::ReqGetStatusEp: begin
          item_c.op = ep_in_range ? usbsrh_pkg::OP_EP_STATUS : usbsrh_pkg::OP_STALL;
        end
        usbsrh_pkg::ReqSetFeatDev,
        usbsrh_pkg::ReqClrFeatDev:    item_c.op = usbsrh_pkg::OP_STALL;
        usbsrh_pkg::ReqSetFeatIf,
        usbsrh_pkg::ReqClrFeatIf,
        usbsrh_pkg::ReqSetLineCoding: item_c.op = usbsrh_pkg::OP_ZLP;
        usbsrh_pkg::ReqSetFeatEp,
        usbsrh_pkg::ReqClrFeatEp: begin
          // endpoint zero halt is never kept
          if (value_word_i == 16'd0 && index_word_i[3:0] != 4'd0 && ep_in_range) begin
            item_c.op = (req_id == usbsrh_pkg::ReqSetFeatEp) ? usbsrh_pkg::OP_SET_HALT
                                                             : usbsrh_pkg::OP_CLR_HALT;
          end else begin
            item_c.op = usbsrh_pkg::OP_STALL;
          end
        end
        usbsrh_pkg::ReqGetLineCoding: item_c.op = usbsrh_pkg::OP_GET_LINE;
        usbsrh_pkg::ReqSetLineState:  item_c.op = usbsrh_pkg::OP_SET_LINE;
        usbsrh_pkg::ReqMscReset:      item_c.op = usbsrh_pkg::OP_MSC_RESET;
        usbsrh_pkg::ReqGetMaxLun: begin
          item_c.op      = usbsrh_pkg::OP_STATUS_ZERO;
          item_c.get_lun = 1'b1;
        end
        default:                      item_c.op = usbsrh_pkg::OP_STALL;
      endcase
    end
  end

  assign valid_d = accept || (valid_q && !item_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_c;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

/* design/usbsrh_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module usbsrh_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_valid_i,
  output logic                       wr_ready_o,
  input  wire usbsrh_pkg::req_item_t wr_item_i,
  output logic                       rd_valid_o,
  input  wire logic                  rd_take_i,
  output usbsrh_pkg::req_item_t      rd_item_o
);

  usbsrh_pkg::req_item_t                   slots_q [usbsrh_pkg::QueueDepth];
  logic [usbsrh_pkg::QPtrW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [usbsrh_pkg::QPtrW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [usbsrh_pkg::QCountW-1:0]          count_q, count_d;
  logic                                    do_wr;
  logic                                    do_rd;

  assign wr_ready_o = count_q != usbsrh_pkg::QCountW'(usbsrh_pkg::QueueDepth);
  assign rd_valid_o = count_q != '0;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_take_i && rd_valid_o;
  assign rd_item_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (32'(wr_ptr_q) == usbsrh_pkg::QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (32'(rd_ptr_q) == usbsrh_pkg::QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

/* design/usbsrh_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module usbsrh_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [6:0]            cfg_data_i,
  input  wire logic                  item_valid_i,
  output logic                       item_take_o,
  input  wire usbsrh_pkg::req_item_t item_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [2:0]                 reply_kind_o,
  output logic [2:0]                 data_source_o,
  output logic [1:0]                 string_number_o,
  output logic [7:0]                 send_length_o,
  output logic [15:0]                reply_word_o,
  output logic [6:0]                 device_address_now_o,
  output logic                       is_configured_o
);

  localparam int unsigned EpCount = usbsrh_pkg::EndpointCount;

  function automatic logic [7:0] clip_len(logic [6:0] natural, logic [15:0] asked);
    logic [7:0] res;
    res = (asked < {9'd0, natural}) ? asked[7:0] : {1'b0, natural};
    return res;
  endfunction

  logic [6:0]           cfg_desc_len_q;
  logic [3:0]           max_lun_q;
  logic [3:0]           line_len_q;

  logic [6:0]           addr_q, addr_d;
  logic [7:0]           config_q, config_d;
  logic [15:0]          line_state_q, line_state_d;
  logic [EpCount-1:0]   stall_in_q, stall_in_d;
  logic [EpCount-1:0]   stall_out_q, stall_out_d;

  logic                 out_valid_q, out_valid_d;
  logic                 take;

  usbsrh_pkg::reply_kind_e kind_c, kind_q;
  usbsrh_pkg::data_src_e   src_c, src_q;
  logic [1:0]           strno_c, strno_q;
  logic [7:0]           len_c, len_q;
  logic [15:0]          word_c, word_q;
  logic                 is_cfg_q;
  logic                 halt_flag;

  // take the queue head whenever the result register frees up this cycle
  assign take        = item_valid_i && (!out_valid_q || pop);
  assign item_take_o = take;
  assign out_valid_d = take || (out_valid_q && !pop);
  assign halt_flag   = item_i.dir_in ? stall_in_q[item_i.ep] : stall_out_q[item_i.ep];

  always_comb begin
    kind_c       = usbsrh_pkg::KIND_STALL;
    src_c        = usbsrh_pkg::SRC_NONE;
    strno_c      = 2'd0;
    len_c        = 8'd0;
    word_c       = 16'd0;
    addr_d       = addr_q;
    config_d     = config_q;
    line_state_d = line_state_q;
    stall_in_d   = stall_in_q;
    stall_out_d  = stall_out_q;
    unique case (item_i.op)
      usbsrh_pkg::OP_BUS_RESET: begin
        kind_c      = usbsrh_pkg::KIND_NONE;
        addr_d      = 7'd0;
        config_d    = 8'd0;
        stall_in_d  = '0;
        stall_out_d = '0;
      end
      usbsrh_pkg::OP_GET_DEV: begin
        kind_c = usbsrh_pkg::KIND_DATA;
        src_c  = usbsrh_pkg::SRC_DEV;
        len_c  = clip_len(usbsrh_pkg::DevDescBytes, item_i.length);
      end
      usbsrh_pkg::OP_GET_CFG: begin
        kind_c = usbsrh_pkg::KIND_DATA;
        src_c  = usbsrh_pkg::SRC_CFG;
        len_c  = clip_len(cfg_desc_len_q, item_i.length);
      end
      usbsrh_pkg::OP_GET_STR: begin
        kind_c  = usbsrh_pkg::KIND_DATA;
        src_c   = usbsrh_pkg::SRC_STR;
        strno_c = item_i.value[1:0];
        len_c   = clip_len(usbsrh_pkg::StrDescBytes, item_i.length);
      end
      usbsrh_pkg::OP_STALL: begin
        kind_c = usbsrh_pkg::KIND_STALL;
      end
      usbsrh_pkg::OP_SET_ADDR: begin
        kind_c = usbsrh_pkg::KIND_ZLP;
        addr_d = item_i.value[6:0];
      end
      usbsrh_pkg::OP_SET_CFG: begin
        kind_c   = usbsrh_pkg::KIND_ZLP;
        config_d = item_i.value[7:0];
      end
      usbsrh_pkg::OP_GET_CFGVAL: begin
        kind_c = usbsrh_pkg::KIND_DATA;
        src_c  = usbsrh_pkg::SRC_CFGVAL;
        word_c = {8'd0, config_q};
        len_c  = clip_len(7'd1, item_i.length);
      end
      usbsrh_pkg::OP_STATUS_ZERO: begin
        kind_c = usbsrh_pkg::KIND_DATA;
        if (item_i.get_lun) begin
          src_c  = usbsrh_pkg::SRC_LUN;
          word_c = {12'd0, max_lun_q};
          len_c  = clip_len(7'd1, item_i.length);
        end else begin
          src_c  = usbsrh_pkg::SRC_STATUS;
          len_c  = clip_len(7'd2, item_i.length);
        end
      end
      usbsrh_pkg::OP_EP_STATUS: begin
        kind_c = usbsrh_pkg::KIND_DATA;
        src_c  = usbsrh_pkg::SRC_STATUS;
        word_c = {15'd0, halt_flag};
        len_c  = clip_len(7'd2, item_i.length);
      end
      usbsrh_pkg::OP_ZLP: begin
        kind_c = usbsrh_pkg::KIND_ZLP;
      end
      usbsrh_pkg::OP_SET_HALT,
      usbsrh_pkg::OP_CLR_HALT: begin
        kind_c = usbsrh_pkg::KIND_ZLP;
        if (item_i.dir_in) begin
          stall_in_d[item_i.ep] = (item_i.op == usbsrh_pkg::OP_SET_HALT);
        end else begin
          stall_out_d[item_i.ep] = (item_i.op == usbsrh_pkg::OP_SET_HALT);
        end
      end
      usbsrh_pkg::OP_GET_LINE: begin
        kind_c = usbsrh_pkg::KIND_DATA;
        src_c  = usbsrh_pkg::SRC_LINE;
        len_c  = clip_len({3'd0, line_len_q}, item_i.length);
      end
      usbsrh_pkg::OP_SET_LINE: begin
        kind_c       = usbsrh_pkg::KIND_ZLP;
        line_state_d = item_i.value;
      end
      usbsrh_pkg::OP_MSC_RESET: begin
        kind_c = usbsrh_pkg::KIND_MSC_RESET;
      end
      default: begin
        kind_c = usbsrh_pkg::KIND_STALL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_desc_len_q <= usbsrh_pkg::CfgDescDefault;
      max_lun_q      <= 4'd0;
      line_len_q     <= usbsrh_pkg::LineLenDefault;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        usbsrh_pkg::CFG_DESC_LEN: cfg_desc_len_q <= cfg_data_i;
        usbsrh_pkg::CFG_MAX_LUN:  max_lun_q      <= cfg_data_i[3:0];
        usbsrh_pkg::CFG_LINE_LEN: line_len_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= 7'd0;
      config_q     <= 8'd0;
      line_state_q <= 16'd0;
      stall_in_q   <= '0;
      stall_out_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        addr_q       <= addr_d;
        config_q     <= config_d;
        line_state_q <= line_state_d;
        stall_in_q   <= stall_in_d;
        stall_out_q  <= stall_out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= kind_c;
      src_q    <= src_c;
      strno_q  <= strno_c;
      len_q    <= len_c;
      word_q   <= word_c;
      is_cfg_q <= config_d != 8'd0;
    end
  end

  assign empty                = !out_valid_q;
  assign reply_kind_o         = kind_q;
  assign data_source_o        = src_q;
  assign string_number_o      = strno_q;
  assign send_length_o        = len_q;
  assign reply_word_o         = word_q;
  assign device_address_now_o = addr_q;
  assign is_configured_o      = is_cfg_q;

  a_bus_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.op == usbsrh_pkg::OP_BUS_RESET)
      |=> (addr_q == 7'd0 && config_q == 8'd0 && stall_in_q == '0 && stall_out_q == '0))
    else $error("bus reset left device state set");

  a_cfg_flag_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (is_cfg_q == (config_q != 8'd0)))
    else $error("configured flag disagrees with configuration");

  a_ep0_never_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_in_q[0] && !stall_out_q[0])
    else $error("endpoint zero halt flag kept");

  a_data_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == usbsrh_pkg::KIND_DATA) |-> (src_q != usbsrh_pkg::SRC_NONE))
    else $error("data reply without source");

endmodule

`default_nettype wire
